// File: rtl/ffha_pkg.sv
// Package for the first-fit heap allocator: sizes, status codes, and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
package ffha_pkg;
  localparam int MaxSegments  = 64;
  localparam int HeaderBytes  = 32;
  localparam int ManagerBytes = 40;
  localparam int MinPayload   = 32;
  localparam int AlignBytes   = 8;
  localparam int IdxW = $clog2(MaxSegments);
  localparam int CntW = IdxW + 1;

  localparam logic [1:0] FuncAlloc = 2'd0;
  localparam logic [1:0] FuncFree  = 2'd1;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StZero    = 3'd1;
  localparam logic [2:0] StNoFit   = 3'd2;
  localparam logic [2:0] StBadAddr = 3'd3;
  localparam logic [2:0] StDouble  = 3'd4;
  localparam logic [2:0] StSmall   = 3'd5;

  typedef enum logic [3:0] {
    OP_NONE, OP_REBUILD, OP_LOAD, OP_READ, OP_SPLIT_SH, OP_SPLIT_FIN, OP_TAKE,
    OP_MARK_FREE, OP_MERGE_NEXT, OP_REM_SH, OP_REM_FIN, OP_MERGE_PREV, OP_STEP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic heap_ok;
    logic func_alloc;
    logic func_free;
    logic zero_req;
    logic scan_done;
    logic hit;
    logic can_split;
    logic is_free;
    logic has_next;
    logic next_free;
    logic has_prev;
    logic prev_free;
    logic split_done;
    logic rem_done;
  } dp_stat_t;
endpackage

// File: rtl/first_fit_heap_allocator_top.sv
// Top level of the first-fit heap allocator with coalescing.
// Channel  | dir | fields
// s_axis   | in  | tdata: req_size[31:0], address[63:32]; tuser: func[1:0]
// m_axis   | out | tdata: granted, used, live, free_bytes; tuser: status
// cfg      | in  | cfg_data: total heap bytes
// One item at a time: a new request is taken only in the idle state. A query scans
// the table one segment after another, and a split or merge moves table entries one
// by one; the longest case is a release that merges both neighbors in a full table.
// rst is synchronous, restores a 1 MiB heap. A stalled result holds the block.
// Depends on ffha_pkg, ffha_ctrl, ffha_datapath.
`timescale 1ns / 1ps
module first_fit_heap_allocator_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,  // req_size[31:0], address[63:32]
  input  logic [1:0]   s_axis_tuser,  // func[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,  // granted[31:0], used[63:32], live[70:64],
                                      // free[102:71], zero pad
  output logic [2:0]   m_axis_tuser,  // status[2:0]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data
);
  import ffha_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [31:0] granted, used, freeb;
  logic [6:0]  live;
  logic        zf, in_fire, idle;

  // a pending config write takes the idle slot before a new item
  assign cfg_ready = idle;
  assign s_axis_tready = idle && !cfg_valid;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  ffha_datapath u_dp (
    .clk, .rst,
    .cfg_we(cfg_valid && cfg_ready), .cfg_data,
    .func_in(s_axis_tuser), .req_in(s_axis_tdata[31:0]), .addr_in(s_axis_tdata[63:32]),
    .cmd, .stat, .granted, .used_total(used), .live_cnt(live), .free_bytes(freeb)
  );

  ffha_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_rdy(idle),
    .out_vld(m_axis_tvalid), .out_rdy(m_axis_tready),
    .status(m_axis_tuser), .zero_fields(zf), .cmd, .stat
  );

  assign m_axis_tdata = zf ? '0 : {1'b0, freeb, live, used, granted};
endmodule

// File: rtl/ffha_datapath.sv
// Datapath of the heap allocator: segment table memory, scan pointer,
// counters and result fields. Depends on ffha_pkg.
`timescale 1ns / 1ps
module ffha_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_data,
  input  logic [1:0]          func_in,
  input  logic [31:0]         req_in,
  input  logic [31:0]         addr_in,
  input  ffha_pkg::dp_cmd_t   cmd,
  output ffha_pkg::dp_stat_t  stat,
  output logic [31:0]         granted,
  output logic [31:0]         used_total,
  output logic [6:0]          live_cnt,
  output logic [31:0]         free_bytes
);
  import ffha_pkg::*;

  logic [31:0] seg_off [MaxSegments];
  logic [31:0] seg_size [MaxSegments];
  logic        seg_free [MaxSegments];

  logic [31:0] heap_total;
  logic        heap_ok;
  logic [CntW-1:0] seg_cnt;
  logic [IdxW:0]   ptr;
  logic [IdxW:0]   sh;
  logic [IdxW:0]   tgt;
  logic [1:0]      func;
  logic [32:0]     sz;
  logic [31:0]     addr;
  logic [31:0]     r_off, r_size;
  logic            r_free;
  logic [31:0]     t_off, t_size;
  logic [31:0]     n_size;
  logic            n_free;

  logic [31:0] sz32;
  logic [33:0] need_split;
  logic [32:0] base_need;
  logic [31:0] live_hdr;
  logic [IdxW-1:0] ptr_i, sh_i, sh_m1, sh_p1;

  assign sz32  = sz[31:0];
  assign ptr_i = ptr[IdxW-1:0];
  assign sh_i  = sh[IdxW-1:0];
  assign sh_m1 = sh_i - 1'b1;
  assign sh_p1 = sh_i + 1'b1;
  assign need_split = {1'b0, sz} + 34'(HeaderBytes + MinPayload);
  assign base_need = 33'(ManagerBytes + HeaderBytes + MinPayload);
  assign live_hdr = 32'(live_cnt) * 32'(HeaderBytes);

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_total <= 32'd1048576;
      heap_ok    <= 1'b1;
      seg_cnt    <= CntW'(1);
      live_cnt   <= '0;
      used_total <= '0;
      granted    <= '0;
      ptr        <= '0;
      sh         <= '0;
      tgt        <= '0;
      seg_off[0]  <= 32'(ManagerBytes);
      seg_size[0] <= 32'd1048576 - 32'(ManagerBytes + HeaderBytes);
      seg_free[0] <= 1'b1;
    end else if (cfg_we) begin
      heap_total <= cfg_data;
      heap_ok    <= {1'b0, cfg_data} >= base_need;
      seg_cnt    <= ({1'b0, cfg_data} >= base_need) ? CntW'(1) : '0;
      live_cnt   <= '0;
      used_total <= '0;
      seg_off[0]  <= 32'(ManagerBytes);
      seg_size[0] <= cfg_data - 32'(ManagerBytes + HeaderBytes);
      seg_free[0] <= 1'b1;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          func    <= func_in;
          sz      <= ({1'b0, req_in} + 33'(AlignBytes - 1)) & ~33'(AlignBytes - 1);
          addr    <= addr_in;
          granted <= '0;
          ptr     <= '0;
        end
        OP_READ: begin
          r_off  <= seg_off[ptr_i];
          r_size <= seg_size[ptr_i];
          r_free <= seg_free[ptr_i];
        end
        OP_STEP: ptr <= ptr + 1'b1;
        OP_REBUILD: begin
          tgt <= ptr;
          sh  <= IdxW'(seg_cnt) == '0 && seg_cnt != '0 ? {1'b1, {IdxW{1'b0}}} :
                 (IdxW+1)'(seg_cnt);
          t_off  <= r_off;
          t_size <= r_size;
        end
        OP_SPLIT_SH: begin
          seg_off[sh_i]  <= seg_off[sh_m1];
          seg_size[sh_i] <= seg_size[sh_m1];
          seg_free[sh_i] <= seg_free[sh_m1];
          sh <= sh - 1'b1;
        end
        OP_SPLIT_FIN: begin
          seg_off[sh_i]  <= t_off + 32'(HeaderBytes) + sz32;
          seg_size[sh_i] <= t_size - sz32 - 32'(HeaderBytes);
          seg_free[sh_i] <= 1'b1;
          t_size  <= sz32;
          seg_cnt <= seg_cnt + 1'b1;
        end
        OP_TAKE: begin
          seg_free[tgt[IdxW-1:0]] <= 1'b0;
          seg_size[tgt[IdxW-1:0]] <= t_size;
          live_cnt   <= live_cnt + 1'b1;
          used_total <= used_total + t_size;
          granted    <= t_off + 32'(HeaderBytes);
        end
        OP_MARK_FREE: begin
          seg_free[tgt[IdxW-1:0]] <= 1'b1;
          live_cnt   <= live_cnt - 1'b1;
          used_total <= used_total - t_size;
          n_size <= seg_size[tgt[IdxW-1:0] + 1'b1];
          n_free <= seg_free[tgt[IdxW-1:0] + 1'b1];
        end
        OP_MERGE_NEXT: begin
          seg_size[tgt[IdxW-1:0]] <= t_size + 32'(HeaderBytes) + n_size;
          t_size <= t_size + 32'(HeaderBytes) + n_size;
          sh <= tgt + 1'b1;
        end
        OP_MERGE_PREV: begin
          seg_size[tgt[IdxW-1:0] - 1'b1] <= n_size + 32'(HeaderBytes) + t_size;
          sh <= tgt;
        end
        OP_REM_SH: begin
          seg_off[sh_i]  <= seg_off[sh_p1];
          seg_size[sh_i] <= seg_size[sh_p1];
          seg_free[sh_i] <= seg_free[sh_p1];
          sh <= sh + 1'b1;
        end
        OP_REM_FIN: seg_cnt <= seg_cnt - 1'b1;
        OP_NONE: begin
          if (tgt != '0) begin
            n_size <= seg_size[tgt[IdxW-1:0] - 1'b1];
            n_free <= seg_free[tgt[IdxW-1:0] - 1'b1];
          end
        end
        default: ;
      endcase
    end
  end

  assign free_bytes = heap_total - used_total - 32'(ManagerBytes) - live_hdr;

  always_comb begin
    stat.heap_ok    = heap_ok;
    stat.func_alloc = func == FuncAlloc;
    stat.func_free  = func == FuncFree;
    stat.zero_req   = sz == '0;
    stat.scan_done  = ptr >= (IdxW+1)'(seg_cnt);
    stat.hit        = (func == FuncAlloc) ? (r_free && {1'b0, r_size} >= sz)
                      : ({1'b0, r_off} + 33'(HeaderBytes) == {1'b0, addr});
    stat.can_split  = {2'b0, r_size} >= need_split && seg_cnt < CntW'(MaxSegments);
    stat.is_free    = r_free;
    stat.has_next   = (tgt + 1'b1) < (IdxW+1)'(seg_cnt);
    stat.next_free  = n_free;
    stat.has_prev   = tgt != '0;
    stat.prev_free  = n_free;
    stat.split_done = sh <= tgt + 1'b1;
    stat.rem_done   = (sh + 1'b1) >= (IdxW+1)'(seg_cnt);
  end
endmodule

// File: rtl/ffha_ctrl.sv
// Controller of the heap allocator: sequences scan, split, merge and
// table shifts, and owns the result handshake. Depends on ffha_pkg.
`timescale 1ns / 1ps
module ffha_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  output logic               in_rdy,
  output logic               out_vld,
  input  logic               out_rdy,
  output logic [2:0]         status,
  output logic               zero_fields,
  output ffha_pkg::dp_cmd_t  cmd,
  input  ffha_pkg::dp_stat_t stat
);
  import ffha_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_READ, S_EVAL, S_SPLIT, S_SPLIT_FIN, S_TAKE, S_FREE,
    S_NXT, S_REM1, S_PREVRD, S_PREV, S_REM2, S_DONE
  } state_t;

  state_t state;
  logic   rem_after_prev;

  assign in_rdy = state == S_IDLE;

  always_comb begin
    cmd.op = OP_NONE;
    unique case (state)
      S_IDLE:      cmd.op = in_fire ? OP_LOAD : OP_NONE;
      S_READ:      cmd.op = OP_READ;
      S_EVAL:      cmd.op = stat.hit ? OP_REBUILD : OP_STEP;
      S_SPLIT:     cmd.op = stat.split_done ? OP_NONE : OP_SPLIT_SH;
      S_SPLIT_FIN: cmd.op = OP_SPLIT_FIN;
      S_TAKE:      cmd.op = OP_TAKE;
      S_FREE:      cmd.op = OP_MARK_FREE;
      S_NXT:       cmd.op = (stat.has_next && stat.next_free) ? OP_MERGE_NEXT : OP_NONE;
      S_REM1, S_REM2: cmd.op = stat.rem_done ? OP_REM_FIN : OP_REM_SH;
      S_PREVRD:    cmd.op = OP_NONE;
      S_PREV:      cmd.op = (stat.has_prev && stat.prev_free) ? OP_MERGE_PREV : OP_NONE;
      default:     cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      out_vld <= 1'b0;
      status  <= StOk;
      zero_fields <= 1'b0;
      rem_after_prev <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_fire) state <= S_CHECK;
        S_CHECK: begin
          zero_fields <= 1'b0;
          status <= StOk;
          if (!stat.heap_ok) begin
            status <= StSmall; zero_fields <= 1'b1; state <= S_DONE; out_vld <= 1'b1;
          end else if (stat.func_alloc && stat.zero_req) begin
            status <= StZero; state <= S_DONE; out_vld <= 1'b1;
          end else if (stat.func_alloc || stat.func_free) begin
            state <= S_READ;
          end else begin
            state <= S_DONE; out_vld <= 1'b1;
          end
        end
        S_READ: begin
          if (stat.scan_done) begin
            status <= stat.func_alloc ? StNoFit : StBadAddr;
            state <= S_DONE; out_vld <= 1'b1;
          end else state <= S_EVAL;
        end
        S_EVAL: begin
          if (!stat.hit) state <= S_READ;
          else if (stat.func_alloc) state <= stat.can_split ? S_SPLIT : S_TAKE;
          else if (stat.is_free) begin
            status <= StDouble; state <= S_DONE; out_vld <= 1'b1;
          end else state <= S_FREE;
        end
        S_SPLIT: if (stat.split_done) state <= S_SPLIT_FIN;
        S_SPLIT_FIN: state <= S_TAKE;
        S_TAKE: begin state <= S_DONE; out_vld <= 1'b1; end
        S_FREE: state <= S_NXT;
        S_NXT: state <= (stat.has_next && stat.next_free) ? S_REM1 : S_PREVRD;
        S_REM1: if (stat.rem_done) state <= S_PREVRD;
        S_PREVRD: state <= S_PREV;
        S_PREV: begin
          if (stat.has_prev && stat.prev_free) state <= S_REM2;
          else begin state <= S_DONE; out_vld <= 1'b1; end
        end
        S_REM2: if (stat.rem_done) begin state <= S_DONE; out_vld <= 1'b1; end
        S_DONE: if (out_rdy) begin out_vld <= 1'b0; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
      rem_after_prev <= state == S_REM2;
    end
  end

`ifndef NO_ASSERTIONS
  a_vld_done: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> state == S_DONE) else $error("result valid outside done");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> state == S_IDLE) else $error("accept while busy");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> status <= StSmall) else $error("status out of range");
  a_rem2_done: assert property (@(posedge clk) disable iff (rst)
    rem_after_prev |-> state == S_REM2 || state == S_DONE) else $error("bad merge exit");
`endif
endmodule
